// File: src/edm_pkg.sv
// ----------------------------------------------------------------------------
// edm_pkg
// Shared types, constants and helpers for the edit distance matcher.
// ----------------------------------------------------------------------------
package edm_pkg;

  localparam int DEF_MAX_LEN = 32;
  localparam int CH_W        = 8;
  localparam int DIST_W      = 8;

  localparam logic [DIST_W-1:0] THRESH_RESET = DIST_W'(1);

  localparam logic OP_PATTERN   = 1'b0;
  localparam logic OP_CANDIDATE = 1'b1;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] ch;
    logic            last;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              within_res;
    logic              pattern_truncated;
  } out_t;

  // candidate character moving down the cell chain
  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic [CH_W-1:0]   ch;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] diag;
  } tok_t;

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v, input logic d);
    logic [DIST_W:0] s;
    s = {1'b0, v} + (DIST_W+1)'(d);
    return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
  endfunction

endpackage

// File: src/edit_distance_matcher.sv
// ----------------------------------------------------------------------------
// edit_distance_matcher
// Levenshtein matcher built as a systolic chain of MAX_LEN cells.
// ----------------------------------------------------------------------------
// Load a pattern with op=0 transactions (last=1 closes it), then stream
// candidates with op=1; the final candidate character (last=1) yields one
// result. Candidate characters are taken one per cycle back to back while
// the chain is not halted; each walks the input register and the chain of
// MAX_LEN cells one cell per cycle while the chain advances, and its result
// is then registered at the output. A pattern character is held off until
// the chain holds no candidate character, longer while a result at the
// chain's end waits for the output. The chain halts only when a result
// reaches its end while the output register is full and out_ready is low.
module edit_distance_matcher import edm_pkg::*; #(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_wr_en,
  input  logic [DIST_W-1:0] cfg_wr_data
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  logic [DIST_W-1:0] thresh_r;
  logic [LEN_W-1:0]  pat_len_r, pat_len_nxt;
  logic              pat_closed_r, pat_closed_nxt;
  logic              trunc_r, trunc_nxt;
  logic              cand_started_r, cand_started_nxt;
  logic [DIST_W-1:0] cand_idx_r, cand_idx_nxt;
  tok_t              tok0_r, tok0_nxt;
  logic              out_valid_r;
  out_t              out_data_r;

  tok_t              tok [MAX_LEN+1];
  logic [MAX_LEN:0]  tok_vld;
  logic              chain_busy;
  logic              adv;
  logic              accept;
  logic              pat_wr;
  logic [LEN_W-1:0]  base_len;
  logic [DIST_W-1:0] ci_old;
  logic [DIST_W-1:0] ci_new;
  logic              res_load;
  tok_t              tail;

  assign tok[0] = tok0_r;
  assign tail   = tok[MAX_LEN];

  always_comb begin
    for (int k = 0; k <= MAX_LEN; k++) begin
      tok_vld[k] = tok[k].vld;
    end
  end

  assign chain_busy = |tok_vld;
  assign adv        = !(tail.vld && tail.last && out_valid_r && !out_ready);
  assign in_ready   = adv && (in_data.op == OP_CANDIDATE || !chain_busy);
  assign accept     = in_valid && in_ready;
  assign pat_wr     = accept && (in_data.op == OP_PATTERN) && (base_len < LEN_W'(MAX_LEN));
  assign base_len   = pat_closed_r ? '0 : pat_len_r;
  assign ci_old     = cand_started_r ? cand_idx_r : '0;
  assign ci_new     = sat_inc(ci_old, 1'b1);
  assign res_load   = adv && tail.vld && tail.last;

  always_comb begin
    pat_len_nxt      = pat_len_r;
    pat_closed_nxt   = pat_closed_r;
    trunc_nxt        = trunc_r;
    cand_started_nxt = cand_started_r;
    cand_idx_nxt     = cand_idx_r;
    tok0_nxt         = tok0_r;
    if (adv) begin
      tok0_nxt.vld = 1'b0;
    end
    if (accept) begin
      if (in_data.op == OP_PATTERN) begin
        cand_started_nxt = 1'b0;
        trunc_nxt        = pat_closed_r ? 1'b0 : trunc_r;
        if (base_len < LEN_W'(MAX_LEN)) begin
          pat_len_nxt = base_len + LEN_W'(1);
        end else begin
          pat_len_nxt = base_len;
          trunc_nxt   = 1'b1;
        end
        pat_closed_nxt = in_data.last;
      end else begin
        pat_closed_nxt   = 1'b1;
        cand_started_nxt = !in_data.last;
        cand_idx_nxt     = ci_new;
        tok0_nxt.vld     = 1'b1;
        tok0_nxt.first   = !cand_started_r;
        tok0_nxt.last    = in_data.last;
        tok0_nxt.ch      = in_data.ch;
        tok0_nxt.left    = ci_new;
        tok0_nxt.diag    = ci_old;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_idx_r   <= cand_idx_nxt;
    if (res_load) begin
      out_data_r.distance          <= tail.left;
      out_data_r.within_res        <= (pat_len_r != '0) && (tail.left <= thresh_r);
      out_data_r.pattern_truncated <= trunc_r;
    end
    if (!rst_n) begin
      thresh_r       <= THRESH_RESET;
      pat_len_r      <= '0;
      pat_closed_r   <= 1'b1;
      trunc_r        <= 1'b0;
      cand_started_r <= 1'b0;
      tok0_r.vld     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      tok0_r         <= tok0_nxt;
      pat_len_r      <= pat_len_nxt;
      pat_closed_r   <= pat_closed_nxt;
      trunc_r        <= trunc_nxt;
      cand_started_r <= cand_started_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    edm_cell #(
      .IDX (j)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .act   (LEN_W'(j) <= pat_len_r),
      .wr_en (pat_wr && (base_len == LEN_W'(j - 1))),
      .wr_ch (in_data.ch),
      .tok_i (tok[j-1]),
      .tok_o (tok[j])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_pat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_PATTERN) |-> !chain_busy)
    else $error("pattern written while chain busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    pat_len_r <= LEN_W'(MAX_LEN))
    else $error("pattern length out of range");

  a_cand_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cand_started_r |-> (cand_idx_r != '0))
    else $error("candidate index zero during candidate");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({tail.vld, tail.last, tail.left}))
    else $error("chain moved while halted");
`endif

endmodule

// File: src/edm_cell.sv
// ----------------------------------------------------------------------------
// edm_cell
// One column of the distance row: holds one pattern character and its
// distance, updates it for each candidate character passing by while the cell lies within the pattern length.
// ----------------------------------------------------------------------------
module edm_cell import edm_pkg::*; #(
  parameter int IDX = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             act,
  input  logic             wr_en,
  input  logic [CH_W-1:0]  wr_ch,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  localparam logic [DIST_W-1:0] INIT_UP = (IDX > 255) ? {DIST_W{1'b1}} : DIST_W'(IDX);

  logic [CH_W-1:0]   p_r;
  logic [DIST_W-1:0] d_r;
  tok_t              tok_r;

  logic [DIST_W-1:0] up;
  logic [DIST_W-1:0] c_sub;
  logic [DIST_W-1:0] c_del;
  logic [DIST_W-1:0] c_ins;
  logic [DIST_W-1:0] best;
  logic [DIST_W-1:0] m1;

  always_comb begin
    up    = tok_i.first ? INIT_UP : d_r;
    c_sub = sat_inc(tok_i.diag, p_r != tok_i.ch);
    c_del = sat_inc(up, 1'b1);
    c_ins = sat_inc(tok_i.left, 1'b1);
    m1    = (c_del < c_sub) ? c_del : c_sub;
    best  = (c_ins < m1) ? c_ins : m1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      p_r <= wr_ch;
    end
    if (adv && tok_i.vld && act) begin
      d_r <= best;
    end
    if (adv) begin
      tok_r.first <= tok_i.first;
      tok_r.last  <= tok_i.last;
      tok_r.ch    <= tok_i.ch;
      tok_r.left  <= act ? best : tok_i.left;
      tok_r.diag  <= up;
    end
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r.vld <= tok_i.vld;
    end
  end

  assign tok_o = tok_r;

endmodule
